// File: rtl/core/rsdc_pkg.sv
// ----------------------------------------------------------------------------
// rsdc_pkg: shared types and constants of the radio sleep controller
// Event kinds, mode codes, register indexes and the structs that travel
// between the register file, the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rsdc_pkg;

   // radio hold reload in seconds
   localparam logic [3:0] RADIO_HOLD_SECONDS = 4'd10;

   // register file geometry
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 17;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLEEPY_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AWAKE_DURATION = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAKE_INTERVAL  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OP_CODE        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OP_MASK        = 3'd4;

   // register reset values
   localparam logic [5:0]  AWAKE_DURATION_RESET = 6'd10;
   localparam logic [16:0] WAKE_INTERVAL_RESET  = 17'd30;
   localparam logic [7:0]  OP_CODE_RESET        = 8'd1;
   localparam logic [7:0]  OP_MASK_RESET        = 8'd1;

   // event kinds
   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_BUTTON    = 2'd1,
      FUNC_CONFIG    = 2'd2,
      FUNC_OPERATION = 2'd3
   } func_type;

   // controller modes
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_NOTIFY = 2'd1,
      MODE_SLEEPY = 2'd2
   } mode_type;

   // configuration registers
   typedef struct packed {
      logic        sleepy_enable;
      logic [5:0]  awake_duration;
      logic [16:0] wake_interval;
      logic [7:0]  op_code;
      logic [7:0]  op_mask;
   } cfg_type;

   // controller state
   typedef struct packed {
      mode_type    mode;
      logic [5:0]  duration_left;
      logic [16:0] interval_left;
      logic [3:0]  radio_hold_left;
      logic        alarm_level;
   } state_type;

   // one input word
   typedef struct packed {
      func_type func;
      logic     route_reachable;
      logic     probe_due;
   } item_type;

   // one result word
   typedef struct packed {
      logic radio_on;
      logic alarm_led;
      logic observer_alert;
      logic sleeping;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/rsdc_csr.sv
// ----------------------------------------------------------------------------
// rsdc_csr: configuration register file
// Holds the five controller settings and takes one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdc_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  wr_en,
   input  wire logic [rsdc_pkg::CSR_INDEX_WIDTH-1:0]  wr_index,
   input  wire logic [rsdc_pkg::CSR_DATA_WIDTH-1:0]   wr_data,
   output rsdc_pkg::cfg_type                          cfg
);
   import rsdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_SLEEPY_ENABLE:  cfg_in.sleepy_enable  = wr_data[0];
            CSR_AWAKE_DURATION: cfg_in.awake_duration = wr_data[5:0];
            CSR_WAKE_INTERVAL:  cfg_in.wake_interval  = wr_data[16:0];
            CSR_OP_CODE:        cfg_in.op_code        = wr_data[7:0];
            CSR_OP_MASK:        cfg_in.op_mask        = wr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleepy_enable  <= 1'b0;
         cfg_ff.awake_duration <= AWAKE_DURATION_RESET;
         cfg_ff.wake_interval  <= WAKE_INTERVAL_RESET;
         cfg_ff.op_code        <= OP_CODE_RESET;
         cfg_ff.op_mask        <= OP_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/rsdc_step.sv
// ----------------------------------------------------------------------------
// rsdc_step: single-event step logic
// Ages the countdowns, applies the event, decides the radio hold and
// advances the notify / normal / sleepy cycle for one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdc_step (
   input  rsdc_pkg::cfg_type    cfg,
   input  rsdc_pkg::state_type  state,
   input  rsdc_pkg::item_type   item,
   output rsdc_pkg::state_type  state_next,
   output rsdc_pkg::result_type result
);
   import rsdc_pkg::*;

   logic [5:0]  dur_ev;
   logic [16:0] int_ev;
   logic [3:0]  hold_ev;
   logic        alarm_ev;
   mode_type    mode_ev;
   logic        must_on;
   logic        notify;
   mode_type    mode_mid;
   mode_type    mode_nxt;
   logic [5:0]  dur_nxt;
   logic [16:0] int_nxt;

   // countdown aging and event action
   always_comb begin
      dur_ev   = state.duration_left;
      int_ev   = state.interval_left;
      hold_ev  = state.radio_hold_left;
      alarm_ev = state.alarm_level;
      mode_ev  = state.mode;
      case (item.func)
         FUNC_TICK: begin
            if (state.duration_left != 6'd0)   dur_ev  = state.duration_left - 6'd1;
            if (state.interval_left != 17'd0)  int_ev  = state.interval_left - 17'd1;
            if (state.radio_hold_left != 4'd0) hold_ev = state.radio_hold_left - 4'd1;
         end
         FUNC_BUTTON: begin
            mode_ev  = MODE_NOTIFY;
            dur_ev   = cfg.awake_duration;
            int_ev   = cfg.wake_interval;
            alarm_ev = 1'b0;
         end
         FUNC_CONFIG: begin
            dur_ev = cfg.awake_duration;
            int_ev = cfg.wake_interval;
         end
         FUNC_OPERATION: begin
            alarm_ev = |(cfg.op_code & cfg.op_mask);
         end
         default: begin
            mode_ev = state.mode;
         end
      endcase
   end

   // radio hold: a running hold keeps the radio on, else the network flags decide
   assign must_on = (hold_ev != 4'd0) || item.probe_due || !item.route_reachable;

   // a notify step reports once and drops to normal
   assign notify   = (mode_ev == MODE_NOTIFY);
   assign mode_mid = notify ? MODE_NORMAL : mode_ev;

   // next mode and countdown reloads
   always_comb begin
      mode_nxt = mode_mid;
      dur_nxt  = dur_ev;
      int_nxt  = int_ev;
      case (mode_mid)
         MODE_SLEEPY: begin
            if (int_ev == 17'd0) begin
               mode_nxt = MODE_NOTIFY;
               dur_nxt  = cfg.awake_duration;
               int_nxt  = cfg.wake_interval;
            end
         end
         default: begin
            mode_nxt = MODE_NORMAL;
            if (dur_ev == 6'd0) begin
               dur_nxt = cfg.awake_duration;
               if (cfg.sleepy_enable) mode_nxt = MODE_SLEEPY;
            end
         end
      endcase
   end

   // next state
   always_comb begin
      state_next.mode            = mode_nxt;
      state_next.duration_left   = dur_nxt;
      state_next.interval_left   = int_nxt;
      state_next.radio_hold_left = (hold_ev == 4'd0 && must_on) ? RADIO_HOLD_SECONDS
                                                                 : hold_ev;
      state_next.alarm_level     = alarm_ev;
   end

   // result word
   always_comb begin
      result.radio_on       = must_on || (mode_nxt != MODE_SLEEPY);
      result.alarm_led      = alarm_ev;
      result.observer_alert = notify;
      result.sleeping       = (mode_nxt == MODE_SLEEPY);
   end

endmodule

`default_nettype wire

// File: rtl/core/radio_sleep_duty_cycle_controller.sv
// ----------------------------------------------------------------------------
// radio_sleep_duty_cycle_controller: duty-cycled radio sleep controller
// Event driven controller for the radio hold, the wake cycle and the alarm LED.
//
// Usage:
//   req_ channel: one event word per handshake, tuser carries the event kind
//   (tick, button, config applied, operation applied), tdata the two network
//   flags. rsp_ channel: exactly one result word per event, in order.
//   csr_ channel: register writes, always ready, effective the next cycle;
//   write only while no event is in flight.
//   The word is captured in the input register when accepted and goes through
//   the step logic into the result register, which drives rsp_tvalid; a
//   stalled receiver can delay that step.
//   Throughput is one event per cycle while the receiver keeps rsp_tready
//   high; the state update sits between the input and result registers.
//   When the receiver stalls, the result register holds its word and the
//   input register can still take one more event; after that req_tready
//   drops until rsp_tready returns.
//   Reset (synchronous, active high) empties both registers, restores the
//   register reset values and puts the controller in the notify mode with
//   full countdowns, no radio hold and the alarm LED off.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_sleep_duty_cycle_controller (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // event channel
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [7:0]                            req_tdata,  // [0] route_reachable, [1] probe_due
   input  wire logic [1:0]                            req_tuser,  // [1:0] func
   // result channel
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [7:0]                                 rsp_tdata,  // [0] radio_on, [1] alarm_led,
                                                                  // [2] observer_alert, [3] sleeping
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [rsdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [rsdc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import rsdc_pkg::*;

   cfg_type    cfg;
   item_type   req_ff;
   logic       req_valid_ff;
   logic       req_valid_in;
   state_type  state_ff;
   state_type  state_next;
   result_type step_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_free;
   logic       step_en;

   // register file
   assign csr_ready = 1'b1;

   rsdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // handshake control
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign step_en      = req_valid_ff && rsp_free;
   assign req_tready   = !req_valid_ff || rsp_free;
   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !rsp_free);
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_tready);

   // step logic
   rsdc_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (req_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.func            <= func_type'(req_tuser);
         req_ff.route_reachable <= req_tdata[0];
         req_ff.probe_due       <= req_tdata[1];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step_result;
      end
   end

   // valid flags and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff             <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.mode            <= MODE_NOTIFY;
         state_ff.duration_left   <= AWAKE_DURATION_RESET;
         state_ff.interval_left   <= WAKE_INTERVAL_RESET;
         state_ff.radio_hold_left <= 4'd0;
         state_ff.alarm_level     <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_en) begin
            state_ff <= state_next;
         end
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.sleeping, rsp_ff.observer_alert,
                        rsp_ff.alarm_led, rsp_ff.radio_on};

endmodule

`default_nettype wire

// File: sim/tb_radio_sleep_duty_cycle_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radio_sleep_duty_cycle_controller: self-checking bench for the controller
// Drives event words through the req_ stream and checks every rsp_ word
// against a cycle-free model of the wake cycle, radio hold and alarm LED.
// Runs a short directed sequence, then several register settings with
// random events and random gaps on both sides of the stream.
// ----------------------------------------------------------------------------

module tb_radio_sleep_duty_cycle_controller;

   import rsdc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_WORDS  = 170;

   // idle settings of the two stream sides
   typedef enum int {
      IDLE_NONE     = 0,
      IDLE_SENDER   = 1,
      IDLE_RECEIVER = 2,
      IDLE_BOTH     = 3
   } idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = 8'd0;  // [0] route_reachable, [1] probe_due
   logic [1:0]                 req_tuser  = 2'd0;  // [1:0] func
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;          // [0] radio_on, [1] alarm_led,
                                                   // [2] observer_alert, [3] sleeping
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   item_type   pending_events[$];
   result_type expected_results[$];
   int         sender_idle_pct   = 0;
   int         receiver_stall_pct = 0;
   int         error_count = 0;
   int         cycle_count = 0;

   // model copy of registers and controller state
   cfg_type    model_cfg;
   mode_type   model_mode;
   logic [5:0] model_duration_left;
   logic [16:0] model_interval_left;
   logic [3:0] model_hold_left;
   logic       model_alarm;

   radio_sleep_duty_cycle_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void reset_model();
      model_cfg.sleepy_enable  = 1'b0;
      model_cfg.awake_duration = AWAKE_DURATION_RESET;
      model_cfg.wake_interval  = WAKE_INTERVAL_RESET;
      model_cfg.op_code        = OP_CODE_RESET;
      model_cfg.op_mask        = OP_MASK_RESET;
      model_mode          = MODE_NOTIFY;
      model_duration_left = AWAKE_DURATION_RESET;
      model_interval_left = WAKE_INTERVAL_RESET;
      model_hold_left     = '0;
      model_alarm         = 1'b0;
   endfunction

   function automatic void reload_countdowns();
      model_duration_left = model_cfg.awake_duration;
      model_interval_left = model_cfg.wake_interval;
   endfunction

   // one controller step: ageing, event action, radio hold, mode cycle
   function automatic result_type predict_controller_step(item_type ev);
      result_type res;
      logic       must_on;
      logic       notify;
      case (ev.func)
         FUNC_TICK: begin
            if (model_duration_left != 0) model_duration_left--;
            if (model_interval_left != 0) model_interval_left--;
            if (model_hold_left != 0) model_hold_left--;
         end
         FUNC_BUTTON: begin
            model_mode = MODE_NOTIFY;
            reload_countdowns();
            model_alarm = 1'b0;
         end
         FUNC_CONFIG: reload_countdowns();
         default: model_alarm = |(model_cfg.op_code & model_cfg.op_mask);
      endcase

      // hold keeps the radio on, otherwise probe or lost route restarts it
      if (model_hold_left != 0) begin
         must_on = 1'b1;
      end else begin
         must_on = ev.probe_due || !ev.route_reachable;
         if (must_on) model_hold_left = RADIO_HOLD_SECONDS;
      end

      notify = 1'b0;
      if (model_mode == MODE_NOTIFY) begin
         notify     = 1'b1;
         model_mode = MODE_NORMAL;
      end

      if (model_mode == MODE_SLEEPY) begin
         if (model_interval_left == 0) begin
            model_mode = MODE_NOTIFY;
            reload_countdowns();
         end
      end else begin
         model_mode = MODE_NORMAL;
         if (model_duration_left == 0) begin
            model_duration_left = model_cfg.awake_duration;
            if (model_cfg.sleepy_enable) model_mode = MODE_SLEEPY;
         end
      end

      res.radio_on       = must_on || (model_mode != MODE_SLEEPY);
      res.alarm_led      = model_alarm;
      res.observer_alert = notify;
      res.sleeping       = (model_mode == MODE_SLEEPY);
      return res;
   endfunction

   // driver: next event word whenever the slot is free
   always @(posedge clock) begin
      item_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            ev.func            = func_type'(req_tuser);
            ev.route_reachable = req_tdata[0];
            ev.probe_due       = req_tdata[1];
            expected_results.push_back(predict_controller_step(ev));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               ev = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= ev.func;
               req_tdata  <= {6'd0, ev.probe_due, ev.route_reachable};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic want, logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor: random back-pressure, compare each result word in order
   always @(posedge clock) begin
      result_type want;
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("radio_on", want.radio_on, rsp_tdata[0]);
            check_field("alarm_led", want.alarm_led, rsp_tdata[1]);
            check_field("observer_alert", want.observer_alert, rsp_tdata[2]);
            check_field("sleeping", want.sleeping, rsp_tdata[3]);
         end
      end
   end

   task automatic push_event(func_type f, logic reachable, logic probe);
      item_type ev;
      ev.func            = f;
      ev.route_reachable = reachable;
      ev.probe_due       = probe;
      pending_events.push_back(ev);
   endtask

   // mostly ticks on a healthy route so the sleep cycle actually runs
   task automatic push_random_event();
      int       pick;
      func_type f;
      pick = $urandom_range(0, 99);
      if (pick < 72)      f = FUNC_TICK;
      else if (pick < 80) f = FUNC_BUTTON;
      else if (pick < 88) f = FUNC_CONFIG;
      else                f = FUNC_OPERATION;
      push_event(f, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
   endtask

   // let every word in flight come back, then drain before returning
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SLEEPY_ENABLE:  model_cfg.sleepy_enable  = value[0];
         CSR_AWAKE_DURATION: model_cfg.awake_duration = value[5:0];
         CSR_WAKE_INTERVAL:  model_cfg.wake_interval  = value[16:0];
         CSR_OP_CODE:        model_cfg.op_code        = value[7:0];
         CSR_OP_MASK:        model_cfg.op_mask        = value[7:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(int sleepy, int duration, int interval, int code, int mask,
                            idle_mode_type idle);
      wait_idle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_reg(CSR_SLEEPY_ENABLE, CSR_DATA_WIDTH'(sleepy));
      write_reg(CSR_AWAKE_DURATION, CSR_DATA_WIDTH'(duration));
      write_reg(CSR_WAKE_INTERVAL, CSR_DATA_WIDTH'(interval));
      write_reg(CSR_OP_CODE, CSR_DATA_WIDTH'(code));
      write_reg(CSR_OP_MASK, CSR_DATA_WIDTH'(mask));
      case (idle)
         IDLE_SENDER:   sender_idle_pct = 49;
         IDLE_RECEIVER: receiver_stall_pct = 49;
         IDLE_BOTH: begin
            sender_idle_pct    = 26;
            receiver_stall_pct = 26;
         end
         default: ;
      endcase
      repeat (PHASE_WORDS) push_random_event();
   endtask

   // stimulus and end of run
   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: first notify, hold reasons, alarm set and clear, reloads
      push_event(FUNC_TICK, 1'b1, 1'b0);
      push_event(FUNC_TICK, 1'b0, 1'b0);
      push_event(FUNC_TICK, 1'b1, 1'b1);
      push_event(FUNC_TICK, 1'b0, 1'b1);
      push_event(FUNC_OPERATION, 1'b1, 1'b0);
      push_event(FUNC_BUTTON, 1'b1, 1'b0);
      push_event(FUNC_CONFIG, 1'b1, 1'b0);
      push_event(FUNC_OPERATION, 1'b0, 1'b1);
      push_event(FUNC_BUTTON, 1'b0, 1'b1);
      // run the duration out with sleep disabled
      repeat (13) push_event(FUNC_TICK, 1'b1, 1'b0);

      // register extremes, zero countdowns and masks that miss
      run_phase(1, 10, 30, 8'hFF, 8'h01, IDLE_NONE);
      run_phase(1, 60, 86400, 8'hAA, 8'h55, IDLE_SENDER);
      run_phase(1, 0, 0, 8'h00, 8'hFF, IDLE_RECEIVER);
      run_phase(0, 63, 17'h1FFFF, 8'hFF, 8'hFF, IDLE_BOTH);
      // short random settings so the sleep cycle turns over often
      for (int p = 0; p < 4; p++) begin
         run_phase($urandom_range(0, 3) != 0, $urandom_range(0, 12), $urandom_range(0, 40),
                   $urandom_range(0, 255), $urandom_range(0, 255), idle_mode_type'(p));
      end

      wait_idle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
